// ----- hw/rtl/trapezoidal_move_profile_top_defines.svh -----
// Assertion helpers shared by the RTL files.
// Each one expects clk and rst_n in scope.
`ifndef TRAPEZOIDAL_MOVE_PROFILE_TOP_DEFINES_SVH
`define TRAPEZOIDAL_MOVE_PROFILE_TOP_DEFINES_SVH

// Same-cycle implication.
`define TMP_ASSERT_NOW(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication.
`define TMP_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- hw/rtl/tmp_pkg.sv -----
package tmp_pkg;

    localparam int DATA_W      = 32;
    localparam int WIDE_W      = 64;
    localparam int LEN_W       = 33;
    localparam int QUEUE_DEPTH = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int IN_W        = 4 * DATA_W;
    localparam int OUT_W       = 7 * DATA_W;

    localparam logic [CFG_IDX_W-1:0] REG_MAX_VELOCITY     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCELERATION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_DECELERATION = 2'd2;

    localparam logic [DATA_W-1:0] LIMIT_RESET = 32'h0001_0000;
    localparam logic [DATA_W-1:0] ALL_ONES    = '1;

    typedef struct packed {
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] d;
        logic [WIDE_W-1:0] ra;
        logic [WIDE_W-1:0] rd;
        logic [WIDE_W-1:0] rsum;
        logic [DATA_W-1:0] tu_trap;
        logic [DATA_W-1:0] td_trap;
    } tmp_cfg_t;

    typedef struct packed {
        logic [DATA_W-1:0] up_dist;
        logic [DATA_W-1:0] cr_dist;
        logic [DATA_W-1:0] dn_dist;
        logic [DATA_W-1:0] cr_time;
        logic              flat;
        logic              ovf_up;
        logic              ovf_dn;
    } tmp_res_t;

    function automatic logic [DATA_W-1:0] sat64(input logic [WIDE_W-1:0] x);
        sat64 = (x[WIDE_W-1:DATA_W] != '0) ? ALL_ONES : x[DATA_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/tmp_div_pipe.sv -----
module tmp_div_pipe #(
    parameter int NW = 65,
    parameter int DW = 33,
    parameter int QW = 49,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    input  logic [SW-1:0] side,
    output logic [QW-1:0] quo,
    output logic [SW-1:0] side_out
);

    logic [DW-1:0] rem_reg  [QW];
    logic [NW-1:0] num_reg  [QW];
    logic [DW-1:0] den_reg  [QW];
    logic [QW-1:0] quo_reg  [QW];
    logic [SW-1:0] side_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [NW-1:0] num_in;
        logic [DW-1:0] den_in;
        logic [QW-1:0] quo_in;
        logic [SW-1:0] side_in;
        logic [DW:0]   trial;
        logic          ge;
        logic [QW-1:0] quo_next;

        if (k == 0) begin : g_first
            assign rem_in  = DW'(num >> QW);
            assign num_in  = num;
            assign den_in  = den;
            assign quo_in  = '0;
            assign side_in = side;
        end
        else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign num_in  = num_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign quo_in  = quo_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        assign trial = {rem_in, num_in[QW-1-k]};
        assign ge    = (trial >= {1'b0, den_in});

        always_comb
        begin
            quo_next           = quo_in;
            quo_next[QW-1-k]   = ge;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? DW'(trial - {1'b0, den_in}) : trial[DW-1:0];
                num_reg[k]  <= num_in;
                den_reg[k]  <= den_in;
                quo_reg[k]  <= quo_next;
                side_reg[k] <= side_in;
            end
        end
    end

    assign quo      = quo_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule

// ----- hw/rtl/tmp_sqrt_pipe.sv -----
module tmp_sqrt_pipe #(
    parameter int RW = 66
) (
    input  logic              clk,
    input  logic              en,
    input  logic [RW-1:0]     rad,
    output logic [RW/2-1:0]   root
);

    localparam int HW = RW / 2;
    localparam int MW = HW + 2;

    logic [MW-1:0] rem_reg  [HW];
    logic [HW-1:0] root_reg [HW];
    logic [RW-1:0] rad_reg  [HW];

    for (genvar k = 0; k < HW; k++) begin : g_stage
        logic [MW-1:0] rem_in;
        logic [HW-1:0] root_in;
        logic [RW-1:0] rad_in;
        logic [MW+1:0] cur;
        logic [MW-1:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
        end
        else begin : g_rest
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
        end

        assign cur   = {rem_in, rad_in[RW-1-2*k -: 2]};
        assign trial = {root_in, 2'b01};
        assign ge    = (cur >= {2'b00, trial});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k]  <= ge ? MW'(cur - {2'b00, trial}) : cur[MW-1:0];
                root_reg[k] <= {root_in[HW-2:0], ge};
                rad_reg[k]  <= rad_in;
            end
        end
    end

    assign root = root_reg[HW-1];

endmodule

// ----- hw/rtl/tmp_queue.sv -----
`include "trapezoidal_move_profile_top_defines.svh"

module tmp_queue #(
    parameter int DEPTH = 4,
    parameter int W     = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] wdata,
    output logic         full,
    input  logic         pop,
    output logic         rvalid,
    output logic [W-1:0] rdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign full   = (count_reg == CW'(DEPTH));
    assign rvalid = (count_reg != '0);
    assign rdata  = mem_reg[rd_ptr_reg];

    `TMP_ASSERT_NOW(a_no_underflow, pop, count_reg != '0, "queue popped while empty")
    `TMP_ASSERT_NOW(a_no_overflow, push, count_reg != CW'(DEPTH), "queue pushed while full")

endmodule

// ----- hw/rtl/tmp_front.sv -----
`include "trapezoidal_move_profile_top_defines.svh"

module tmp_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tmp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tmp_pkg::DATA_W-1:0]     cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tmp_pkg::IN_W-1:0]       s_tdata,
    output logic                           push,
    output logic [2*tmp_pkg::DATA_W-1:0]   wdata,
    input  logic                           full,
    output tmp_pkg::tmp_cfg_t              cfg
);

    import tmp_pkg::*;

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [1:0] JOB_RA = 2'd0;
    localparam logic [1:0] JOB_RD = 2'd1;
    localparam logic [1:0] JOB_TU = 2'd2;
    localparam logic [1:0] JOB_TD = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        job_reg, job_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [WIDE_W-1:0] num_reg, num_next;
    logic [LEN_W-1:0]  den_reg, den_next;
    logic [LEN_W-1:0]  rem_reg, rem_next;
    logic [DATA_W-1:0] v_reg, a_reg, d_reg;
    logic [WIDE_W-1:0] ra_reg, rd_reg, rsum_reg;
    logic [DATA_W-1:0] tu_reg, td_reg;
    logic [DATA_W-1:0] wval;
    logic [LEN_W:0]    trial;
    logic              ge;
    logic [WIDE_W-1:0] quot;
    logic [WIDE_W-1:0] vsq;
    logic              done;

    logic signed [DATA_W:0] dx_s, dy_s;
    logic [DATA_W-1:0]      dx, dy;

    assign wval  = (cfg_data == '0) ? DATA_W'(1) : cfg_data;
    assign vsq   = v_reg * v_reg;
    assign trial = {rem_reg, num_reg[WIDE_W-1]};
    assign ge    = (trial >= {1'b0, den_reg});
    assign quot  = {num_reg[WIDE_W-2:0], ge};
    assign done  = (cnt_reg == 6'd63);

    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_RUN;
                unique case (job_reg)
                    JOB_RA:
                    begin
                        num_next = vsq;
                        den_next = {a_reg, 1'b0};
                    end
                    JOB_RD:
                    begin
                        num_next = vsq;
                        den_next = {d_reg, 1'b0};
                    end
                    JOB_TU:
                    begin
                        num_next = {16'd0, v_reg, 16'd0};
                        den_next = {1'b0, a_reg};
                    end
                    JOB_TD:
                    begin
                        num_next = {16'd0, v_reg, 16'd0};
                        den_next = {1'b0, d_reg};
                    end
                    default:
                    begin
                        num_next = num_reg;
                    end
                endcase
            end
            ST_RUN:
            begin
                rem_next = ge ? LEN_W'(trial - {1'b0, den_reg}) : trial[LEN_W-1:0];
                num_next = quot;
                cnt_next = cnt_reg + 1'b1;
                if (done)
                begin
                    if (job_reg == JOB_TD)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        job_next   = job_reg + 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_DONE:
            begin
                state_next = ST_DONE;
            end
            default:
            begin
                state_next = ST_LOAD;
                job_next   = JOB_RA;
            end
        endcase
        if (cfg_we)
        begin
            state_next = ST_LOAD;
            job_next   = JOB_RA;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            job_reg   <= JOB_RA;
            cnt_reg   <= '0;
            v_reg     <= LIMIT_RESET;
            a_reg     <= LIMIT_RESET;
            d_reg     <= LIMIT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            job_reg   <= job_next;
            cnt_reg   <= cnt_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_MAX_VELOCITY:     v_reg <= wval;
                    REG_MAX_ACCELERATION: a_reg <= wval;
                    REG_MAX_DECELERATION: d_reg <= wval;
                    default:              v_reg <= v_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
        if (state_reg == ST_RUN && done)
        begin
            case (job_reg)
                JOB_RA:
                begin
                    ra_reg <= quot;
                end
                JOB_RD:
                begin
                    rd_reg   <= quot;
                    rsum_reg <= ra_reg + quot;
                end
                JOB_TU:
                begin
                    tu_reg <= sat64(quot);
                end
                default:
                begin
                    td_reg <= sat64(quot);
                end
            endcase
        end
    end

    assign dx_s = $signed({s_tdata[95], s_tdata[95:64]}) - $signed({s_tdata[31], s_tdata[31:0]});
    assign dy_s = $signed({s_tdata[127], s_tdata[127:96]})
                - $signed({s_tdata[63], s_tdata[63:32]});
    assign dx   = dx_s[DATA_W] ? DATA_W'(-dx_s) : dx_s[DATA_W-1:0];
    assign dy   = dy_s[DATA_W] ? DATA_W'(-dy_s) : dy_s[DATA_W-1:0];

    assign s_tready = (state_reg == ST_DONE) && !full;
    assign push     = s_tvalid && s_tready;
    assign wdata    = {dy, dx};

    assign cfg.v       = v_reg;
    assign cfg.a       = a_reg;
    assign cfg.d       = d_reg;
    assign cfg.ra      = ra_reg;
    assign cfg.rd      = rd_reg;
    assign cfg.rsum    = rsum_reg;
    assign cfg.tu_trap = tu_reg;
    assign cfg.td_trap = td_reg;

    `TMP_ASSERT_NOW(a_hold_while_calc, state_reg != ST_DONE, !s_tready, "move taken before limits ready")
    `TMP_ASSERT_NEXT(a_restart_on_write, cfg_we, state_reg == ST_LOAD && job_reg == JOB_RA, "limit unit did not restart")

endmodule

// ----- hw/rtl/tmp_back.sv -----
`include "trapezoidal_move_profile_top_defines.svh"

module tmp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tmp_pkg::tmp_cfg_t             cfg,
    input  logic                          q_valid,
    input  logic [2*tmp_pkg::DATA_W-1:0]  q_data,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tmp_pkg::OUT_W-1:0]     m_tdata
);

    import tmp_pkg::*;

    localparam int DIVA_QW = 49;
    localparam int DIVA_NW = 65;
    localparam int DIVB_NW = 66;
    localparam int SQB_LAT = DATA_W;
    localparam int SIDE_A  = 2 * LEN_W + 1;
    localparam int SIDE_U  = $bits(tmp_res_t) - 1;
    localparam int LAT     = 2 + LEN_W + 1 + DIVA_QW + 2 + WIDE_W + SQB_LAT + 1;

    logic [LAT-1:0]        vld_reg;
    logic                  en;

    logic [WIDE_W-1:0]     sx_reg, sy_reg;
    logic [WIDE_W:0]       sum_reg;
    logic [LEN_W-1:0]      len;

    logic                  tri_reg;
    logic [DIVA_NW-1:0]    prod_reg;
    logic [LEN_W-1:0]      crt_reg, len2_reg;
    logic [DIVA_NW-1:0]    num_a;
    logic [LEN_W-1:0]      den_a;
    logic [DIVA_QW-1:0]    qa;
    logic [SIDE_A-1:0]     side_a;

    logic [LEN_W-1:0]      a_len, a_crt, upq, dnq;
    logic                  a_tri;
    tmp_res_t              p3_res_reg, p4_res_reg;
    logic [LEN_W-1:0]      up33_reg, dn33_reg;
    logic                  ovf_u, ovf_d;
    logic [DIVB_NW-1:0]    numu_reg, numd_reg;

    logic [WIDE_W-1:0]     qu, qd;
    logic [SIDE_U-1:0]     side_u;
    logic                  side_d;
    tmp_res_t              res_b;
    tmp_res_t              hold_reg [SQB_LAT];
    logic [DATA_W-1:0]     root_u, root_d;

    logic [DATA_W-1:0]     tu, td;
    logic [DATA_W+1:0]     tot;
    logic [OUT_W-1:0]      out_reg;

    assign en    = !vld_reg[LAT-1] || m_tready;
    assign q_pop = en && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], q_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx_reg  <= q_data[DATA_W-1:0] * q_data[DATA_W-1:0];
            sy_reg  <= q_data[2*DATA_W-1:DATA_W] * q_data[2*DATA_W-1:DATA_W];
            sum_reg <= {1'b0, sx_reg} + {1'b0, sy_reg};
        end
    end

    tmp_sqrt_pipe #(.RW(2 * LEN_W)) u_sqrt_len (
        .clk  (clk),
        .en   (en),
        .rad  ({1'b0, sum_reg}),
        .root (len)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tri_reg  <= ({31'd0, len} < cfg.rsum);
            prod_reg <= len * cfg.d;
            crt_reg  <= LEN_W'({31'd0, len} - cfg.rsum);
            len2_reg <= len;
        end
    end

    assign num_a = tri_reg ? prod_reg : {16'd0, crt_reg, 16'd0};
    assign den_a = tri_reg ? ({1'b0, cfg.a} + {1'b0, cfg.d}) : {1'b0, cfg.v};

    tmp_div_pipe #(.NW(DIVA_NW), .DW(LEN_W), .QW(DIVA_QW), .SW(SIDE_A)) u_div_split (
        .clk      (clk),
        .en       (en),
        .num      (num_a),
        .den      (den_a),
        .side     ({len2_reg, tri_reg, crt_reg}),
        .quo      (qa),
        .side_out (side_a)
    );

    assign a_len = side_a[SIDE_A-1:LEN_W+1];
    assign a_tri = side_a[LEN_W];
    assign a_crt = side_a[LEN_W-1:0];
    assign upq   = qa[LEN_W-1:0];
    assign dnq   = a_len - upq;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_res_reg.up_dist <= a_tri ? sat64(64'(upq)) : sat64(cfg.ra);
            p3_res_reg.dn_dist <= a_tri ? sat64(64'(dnq)) : sat64(cfg.rd);
            p3_res_reg.cr_dist <= a_tri ? '0 : sat64(64'(a_crt));
            p3_res_reg.cr_time <= (a_tri || (qa[DIVA_QW-1:DATA_W] != '0)) ?
                                  (a_tri ? '0 : ALL_ONES) : qa[DATA_W-1:0];
            p3_res_reg.flat    <= a_tri || (a_crt == '0);
            p3_res_reg.ovf_up  <= 1'b0;
            p3_res_reg.ovf_dn  <= 1'b0;
            up33_reg           <= a_tri ? upq : cfg.ra[LEN_W-1:0];
            dn33_reg           <= a_tri ? dnq : cfg.rd[LEN_W-1:0];
        end
    end

    assign ovf_u = ({30'd0, up33_reg[LEN_W-1:DATA_W-1]} >= cfg.a);
    assign ovf_d = ({30'd0, dn33_reg[LEN_W-1:DATA_W-1]} >= cfg.d);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_res_reg        <= {p3_res_reg[SIDE_U:2], ovf_u, ovf_d};
            numu_reg          <= ovf_u ? '0 : {up33_reg, 33'd0};
            numd_reg          <= ovf_d ? '0 : {dn33_reg, 33'd0};
        end
    end

    tmp_div_pipe #(.NW(DIVB_NW), .DW(DATA_W), .QW(WIDE_W), .SW(SIDE_U)) u_div_up (
        .clk      (clk),
        .en       (en),
        .num      (numu_reg),
        .den      (cfg.a),
        .side     (p4_res_reg[SIDE_U:1]),
        .quo      (qu),
        .side_out (side_u)
    );

    tmp_div_pipe #(.NW(DIVB_NW), .DW(DATA_W), .QW(WIDE_W), .SW(1)) u_div_dn (
        .clk      (clk),
        .en       (en),
        .num      (numd_reg),
        .den      (cfg.d),
        .side     (p4_res_reg.ovf_dn),
        .quo      (qd),
        .side_out (side_d)
    );

    assign res_b = {side_u, side_d};

    tmp_sqrt_pipe #(.RW(WIDE_W)) u_sqrt_up (
        .clk  (clk),
        .en   (en),
        .rad  (qu),
        .root (root_u)
    );

    tmp_sqrt_pipe #(.RW(WIDE_W)) u_sqrt_dn (
        .clk  (clk),
        .en   (en),
        .rad  (qd),
        .root (root_d)
    );

    for (genvar k = 0; k < SQB_LAT; k++) begin : g_hold
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hold_reg[k] <= (k == 0) ? res_b : hold_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    assign tu  = hold_reg[SQB_LAT-1].flat ?
                 (hold_reg[SQB_LAT-1].ovf_up ? ALL_ONES : root_u) : cfg.tu_trap;
    assign td  = hold_reg[SQB_LAT-1].flat ?
                 (hold_reg[SQB_LAT-1].ovf_dn ? ALL_ONES : root_d) : cfg.td_trap;
    assign tot = {2'b00, tu} + {2'b00, hold_reg[SQB_LAT-1].cr_time} + {2'b00, td};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= {(tot[DATA_W+1:DATA_W] != '0) ? ALL_ONES : tot[DATA_W-1:0],
                        td, hold_reg[SQB_LAT-1].cr_time, tu,
                        hold_reg[SQB_LAT-1].dn_dist,
                        hold_reg[SQB_LAT-1].cr_dist,
                        hold_reg[SQB_LAT-1].up_dist};
        end
    end

    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = out_reg;

    `TMP_ASSERT_NOW(a_pop_needs_room, q_pop, en && q_valid, "pop without pipeline advance")
    `TMP_ASSERT_NEXT(a_drain, vld_reg[LAT-1] && m_tready && !vld_reg[LAT-2], !m_tvalid, "result repeated")

endmodule

// ----- hw/rtl/trapezoidal_move_profile_top.sv -----
// Channel   Dir  Payload (low bit first)                                    Handshake
// s_axis    in   start_x, start_y, dest_x, dest_y (32b signed each)         tvalid/tready
// m_axis    out  ramp_up_distance, cruise_distance, ramp_down_distance,     tvalid/tready
//                ramp_up_time, cruise_time, ramp_down_time, total_time
// cfg       in   max_velocity, max_acceleration, max_deceleration           cfg_we
//
// One move per cycle sustained while the limits are ready and m_tready is high; each move
// passes through the queue, length root, split divider, phase-time dividers and roots in series.
// After reset and after each register write the shared 64-step limit divider computes
// four quotients in turn; s_tready stays low until it finishes.
// A stalled result freezes the back pipeline; the input queue keeps taking moves until it is full.
module trapezoidal_move_profile_top #(
    parameter int QUEUE_DEPTH = tmp_pkg::QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tmp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tmp_pkg::DATA_W-1:0]    cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // start_x, start_y, dest_x, dest_y
    input  logic [tmp_pkg::IN_W-1:0]      s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // ramp_up_distance, cruise_distance, ramp_down_distance, ramp_up_time,
    // cruise_time, ramp_down_time, total_time
    output logic [tmp_pkg::OUT_W-1:0]     m_tdata
);

    import tmp_pkg::*;

    logic                  push, full, pop, rvalid;
    logic [2*DATA_W-1:0]   wdata, rdata;
    tmp_cfg_t              cfg;

    tmp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .wdata     (wdata),
        .full      (full),
        .cfg       (cfg)
    );

    tmp_queue #(.DEPTH(QUEUE_DEPTH), .W(2 * DATA_W)) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (wdata),
        .full   (full),
        .pop    (pop),
        .rvalid (rvalid),
        .rdata  (rdata)
    );

    tmp_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_valid  (rvalid),
        .q_data   (rdata),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
